// File: rtl/core/t16c_pkg.sv
// Shared constants, codes and handshake structs of the tiny 16-bit CPU step block.
package t16c_pkg;

    // Data path and storage geometry.
    localparam int DATA_W    = 16;
    localparam int MEM_WORDS = 128;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int STEP_W    = $clog2(DATA_W);

    // Request types on the input channel.
    localparam logic [1:0] REQ_EXEC = 2'd0;
    localparam logic [1:0] REQ_WREG = 2'd1;
    localparam logic [1:0] REQ_WMEM = 2'd2;

    // Instruction opcodes.
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_STORE = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_SUB   = 4'd4;
    localparam logic [3:0] OP_MUL   = 4'd5;
    localparam logic [3:0] OP_DIV   = 4'd6;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    // Command from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    // Status from the arithmetic unit back to the sequencer.
    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

endpackage

// File: rtl/core/t16c_regfile.sv
// Sixteen-entry register file with one write port, one registered read port and valid bits.
module t16c_regfile (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [t16c_pkg::REG_AW-1:0]  wr_addr,
    input  logic [t16c_pkg::DATA_W-1:0]  wr_data,
    input  logic [t16c_pkg::REG_AW-1:0]  rd_addr,
    output logic [t16c_pkg::DATA_W-1:0]  rd_data
);

    logic [t16c_pkg::DATA_W-1:0]    mem_array [t16c_pkg::REG_COUNT];
    logic [t16c_pkg::REG_COUNT-1:0] valid_reg;
    logic [t16c_pkg::DATA_W-1:0]    rd_data_reg;

    // Valid bits make every register read as zero until it is first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Storage write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem_array[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/t16c_mem.sv
// Unified word memory with one write port, one registered read port and per-word valid bits.
module t16c_mem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [t16c_pkg::MEM_AW-1:0]  wr_addr,
    input  logic [t16c_pkg::DATA_W-1:0]  wr_data,
    input  logic [t16c_pkg::MEM_AW-1:0]  rd_addr,
    output logic [t16c_pkg::DATA_W-1:0]  rd_data
);

    logic [t16c_pkg::DATA_W-1:0]    mem_array [t16c_pkg::MEM_WORDS];
    logic [t16c_pkg::MEM_WORDS-1:0] valid_reg;
    logic [t16c_pkg::DATA_W-1:0]    rd_data_reg;

    // A word that was never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Storage write and registered read; a read in the write cycle returns the old word.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem_array[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/t16c_alu.sv
// Shared arithmetic unit: one 17-bit adder reused for add, sub, shift-add multiply and divide.
module t16c_alu (
    input  logic                         clk,
    input  logic                         rst_n,
    input  t16c_pkg::alu_req_t           req,
    input  logic [t16c_pkg::DATA_W-1:0]  op_a,
    input  logic [t16c_pkg::DATA_W-1:0]  op_b,
    output t16c_pkg::alu_rsp_t           rsp,
    output logic [t16c_pkg::DATA_W-1:0]  result
);

    logic                          busy_reg;
    logic                          done_reg;
    logic                          dz_reg;
    t16c_pkg::alu_op_t             op_reg;
    logic [t16c_pkg::STEP_W-1:0]   cnt_reg;
    logic [t16c_pkg::DATA_W-1:0]   acc_reg;
    logic [t16c_pkg::DATA_W-1:0]   q_reg;
    logic [t16c_pkg::DATA_W-1:0]   m_reg;

    logic [t16c_pkg::DATA_W:0]     add_x;
    logic [t16c_pkg::DATA_W:0]     add_y;
    logic                          add_sub;
    logic [t16c_pkg::DATA_W:0]     add_sum;
    logic                          last_step;

    // Operand selection for the single adder.
    always_comb
    begin
        add_x   = {1'b0, acc_reg};
        add_y   = {1'b0, m_reg};
        add_sub = 1'b0;
        case (op_reg)
            t16c_pkg::ALU_ADD:
            begin
                add_sub = 1'b0;
            end
            t16c_pkg::ALU_SUB:
            begin
                add_sub = 1'b1;
            end
            t16c_pkg::ALU_MUL:
            begin
                add_y = q_reg[0] ? {1'b0, m_reg} : '0;
            end
            t16c_pkg::ALU_DIV:
            begin
                // Trial subtraction of the divisor from the shifted partial remainder.
                add_x   = {acc_reg, q_reg[t16c_pkg::DATA_W-1]};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
        add_sum   = add_sub ? (add_x - add_y) : (add_x + add_y);
        last_step = (op_reg == t16c_pkg::ALU_ADD) || (op_reg == t16c_pkg::ALU_SUB) ||
                    (cnt_reg == t16c_pkg::STEP_W'(t16c_pkg::DATA_W - 1));
    end

    // Iteration sequencer: add and sub use the adder once, one bit per cycle for mul and div.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
            op_reg   <= t16c_pkg::ALU_ADD;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            q_reg    <= '0;
            m_reg    <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            op_reg   <= req.op;
            cnt_reg  <= '0;
            acc_reg  <= ((req.op == t16c_pkg::ALU_ADD) || (req.op == t16c_pkg::ALU_SUB)) ?
                        op_a : '0;
            q_reg    <= op_a;
            m_reg    <= op_b;
            dz_reg   <= (req.op == t16c_pkg::ALU_DIV) && (op_b == '0);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            case (op_reg)
                t16c_pkg::ALU_MUL:
                begin
                    acc_reg <= add_sum[t16c_pkg::DATA_W-1:0];
                    m_reg   <= {m_reg[t16c_pkg::DATA_W-2:0], 1'b0};
                    q_reg   <= {1'b0, q_reg[t16c_pkg::DATA_W-1:1]};
                end
                t16c_pkg::ALU_DIV:
                begin
                    // Restoring step; a zero divisor never borrows and yields all ones.
                    if (!add_sum[t16c_pkg::DATA_W])
                    begin
                        acc_reg <= add_sum[t16c_pkg::DATA_W-1:0];
                        q_reg   <= {q_reg[t16c_pkg::DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg <= add_x[t16c_pkg::DATA_W-1:0];
                        q_reg   <= {q_reg[t16c_pkg::DATA_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_reg <= add_sum[t16c_pkg::DATA_W-1:0];
                end
            endcase
            if (last_step)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.div_zero = dz_reg;
    assign result       = (op_reg == t16c_pkg::ALU_DIV) ? q_reg : acc_reg;

endmodule

// File: rtl/core/tiny_16bit_cpu_step.sv
// Top level of the tiny 16-bit CPU step block: request sequencer, storage and result register.
//
// Usage: an input transfer carries one request. Request type 0 executes one
// instruction step, type 1 preloads a register and type 2 preloads a memory
// word. Every request yields exactly one result transfer on the output
// channel, in order.
// Sequencing: one request at a time; in_ready is high only while the
// sequencer is idle. A preload, or a step while halted, goes straight to its
// result; a step fetches the word at pc and halts on a fetched zero word.
// Otherwise it makes two register file reads on the single read port, then
// store writes memory, load reads memory, unassigned opcodes write zero, and
// add, sub, mul and div run on the shared arithmetic unit, which iterates
// one bit per cycle for mul and div. The next request is accepted from the
// cycle after the result is loaded.
// Reset: registers, memory, program counter and halt flag all read as zero;
// valid bits clear the storage at once, so no clearing pass is needed.
// Stall: a result waits in the output register while out_ready is low; a
// following request is still accepted and processed, and its result is held
// in the sequencer until the output register is free.
module tiny_16bit_cpu_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [6:0]  target_index,
    input  logic [15:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        halted,
    output logic [3:0]  executed_opcode,
    output logic        reg_written,
    output logic [3:0]  dest_reg,
    output logic [15:0] dest_value,
    output logic        mem_written,
    output logic [6:0]  mem_address,
    output logic        divide_by_zero,
    output logic [6:0]  next_pc
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ_A,
        S_READ_B,
        S_LOAD,
        S_ALU,
        S_FINISH
    } state_t;

    state_t                            state_reg, state_next;
    logic [t16c_pkg::MEM_AW-1:0]       pc_reg, pc_next;
    logic                              halt_reg, halt_next;
    logic [t16c_pkg::DATA_W-1:0]       ir_reg, ir_next;
    logic [t16c_pkg::DATA_W-1:0]       a_reg, a_next;

    // Result being built for the current request.
    logic [3:0]                        res_opcode_reg, res_opcode_next;
    logic                              res_wreg_reg, res_wreg_next;
    logic [t16c_pkg::REG_AW-1:0]       res_dreg_reg, res_dreg_next;
    logic [t16c_pkg::DATA_W-1:0]       res_dval_reg, res_dval_next;
    logic                              res_wmem_reg, res_wmem_next;
    logic [t16c_pkg::MEM_AW-1:0]       res_maddr_reg, res_maddr_next;
    logic                              res_dz_reg, res_dz_next;

    // Output register.
    logic                              out_valid_reg, out_valid_next;
    logic                              halted_reg, halted_next;
    logic [3:0]                        opcode_reg, opcode_next;
    logic                              wreg_reg, wreg_next;
    logic [t16c_pkg::REG_AW-1:0]       dreg_reg, dreg_next;
    logic [t16c_pkg::DATA_W-1:0]       dval_reg, dval_next;
    logic                              wmem_reg, wmem_next;
    logic [t16c_pkg::MEM_AW-1:0]       maddr_reg, maddr_next;
    logic                              dz_reg, dz_next;
    logic [t16c_pkg::MEM_AW-1:0]       npc_reg, npc_next;

    // Storage and arithmetic unit hookup.
    logic                              rf_we;
    logic [t16c_pkg::REG_AW-1:0]       rf_waddr;
    logic [t16c_pkg::DATA_W-1:0]       rf_wdata;
    logic [t16c_pkg::REG_AW-1:0]       rf_raddr;
    logic [t16c_pkg::DATA_W-1:0]       rf_rdata;
    logic                              mem_we;
    logic [t16c_pkg::MEM_AW-1:0]       mem_waddr;
    logic [t16c_pkg::DATA_W-1:0]       mem_wdata;
    logic [t16c_pkg::MEM_AW-1:0]       mem_raddr;
    logic [t16c_pkg::DATA_W-1:0]       mem_rdata;
    t16c_pkg::alu_req_t                alu_req;
    t16c_pkg::alu_rsp_t                alu_rsp;
    logic [t16c_pkg::DATA_W-1:0]       alu_result;

    logic                              in_xfer;
    logic [3:0]                        ir_opcode;
    logic [t16c_pkg::REG_AW-1:0]       ir_rt;
    logic [t16c_pkg::REG_AW-1:0]       ir_rd;
    logic [t16c_pkg::MEM_AW-1:0]       eff_addr;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign ir_opcode = ir_reg[15:12];
    assign ir_rt     = ir_reg[7:4];
    assign ir_rd     = ir_reg[3:0];
    assign eff_addr  = a_reg[t16c_pkg::MEM_AW-1:0] + t16c_pkg::MEM_AW'(ir_rd);

    t16c_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_addr (rf_raddr),
        .rd_data (rf_rdata)
    );

    t16c_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    t16c_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .op_a   (a_reg),
        .op_b   (rf_rdata),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    // Sequencer next-state logic and storage port control.
    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        halt_next       = halt_reg;
        ir_next         = ir_reg;
        a_next          = a_reg;
        res_opcode_next = res_opcode_reg;
        res_wreg_next   = res_wreg_reg;
        res_dreg_next   = res_dreg_reg;
        res_dval_next   = res_dval_reg;
        res_wmem_next   = res_wmem_reg;
        res_maddr_next  = res_maddr_reg;
        res_dz_next     = res_dz_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        halted_next     = halted_reg;
        opcode_next     = opcode_reg;
        wreg_next       = wreg_reg;
        dreg_next       = dreg_reg;
        dval_next       = dval_reg;
        wmem_next       = wmem_reg;
        maddr_next      = maddr_reg;
        dz_next         = dz_reg;
        npc_next        = npc_reg;

        rf_we           = 1'b0;
        rf_waddr        = ir_rd;
        rf_wdata        = alu_result;
        rf_raddr        = ir_rt;
        mem_we          = 1'b0;
        mem_waddr       = eff_addr;
        mem_wdata       = rf_rdata;
        mem_raddr       = pc_reg;
        alu_req.start   = 1'b0;
        alu_req.op      = t16c_pkg::ALU_ADD;

        case (state_reg)
            S_IDLE:
            begin
                // The memory port reads the word at pc so a step can decode next cycle.
                if (in_xfer)
                begin
                    res_opcode_next = '0;
                    res_wreg_next   = 1'b0;
                    res_dreg_next   = '0;
                    res_dval_next   = '0;
                    res_wmem_next   = 1'b0;
                    res_maddr_next  = '0;
                    res_dz_next     = 1'b0;
                    state_next      = S_FINISH;
                    case (req_type)
                        t16c_pkg::REQ_EXEC:
                        begin
                            if (!halt_reg)
                            begin
                                state_next = S_DECODE;
                            end
                        end
                        t16c_pkg::REQ_WREG:
                        begin
                            rf_we    = 1'b1;
                            rf_waddr = target_index[t16c_pkg::REG_AW-1:0];
                            rf_wdata = write_data;
                        end
                        t16c_pkg::REQ_WMEM:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = target_index[t16c_pkg::MEM_AW-1:0];
                            mem_wdata = write_data;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_DECODE:
            begin
                pc_next = pc_reg + 1'b1;
                if (mem_rdata == '0)
                begin
                    halt_next  = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    ir_next         = mem_rdata;
                    res_opcode_next = mem_rdata[15:12];
                    rf_raddr        = mem_rdata[11:8];
                    state_next      = S_READ_A;
                end
            end
            S_READ_A:
            begin
                a_next     = rf_rdata;
                rf_raddr   = ir_rt;
                state_next = S_READ_B;
            end
            S_READ_B:
            begin
                // rf_rdata now holds the rt operand.
                case (ir_opcode)
                    t16c_pkg::OP_LOAD:
                    begin
                        mem_raddr      = eff_addr;
                        res_maddr_next = eff_addr;
                        res_wreg_next  = 1'b1;
                        res_dreg_next  = ir_rt;
                        state_next     = S_LOAD;
                    end
                    t16c_pkg::OP_STORE:
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = eff_addr;
                        mem_wdata      = rf_rdata;
                        res_maddr_next = eff_addr;
                        res_wmem_next  = 1'b1;
                        state_next     = S_FINISH;
                    end
                    t16c_pkg::OP_ADD:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = t16c_pkg::ALU_ADD;
                        state_next    = S_ALU;
                    end
                    t16c_pkg::OP_SUB:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = t16c_pkg::ALU_SUB;
                        state_next    = S_ALU;
                    end
                    t16c_pkg::OP_MUL:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = t16c_pkg::ALU_MUL;
                        state_next    = S_ALU;
                    end
                    t16c_pkg::OP_DIV:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = t16c_pkg::ALU_DIV;
                        state_next    = S_ALU;
                    end
                    default:
                    begin
                        // Unassigned opcodes clear the destination register.
                        rf_we         = 1'b1;
                        rf_waddr      = ir_rd;
                        rf_wdata      = '0;
                        res_wreg_next = 1'b1;
                        res_dreg_next = ir_rd;
                        res_dval_next = '0;
                        state_next    = S_FINISH;
                    end
                endcase
            end
            S_LOAD:
            begin
                rf_we         = 1'b1;
                rf_waddr      = ir_rt;
                rf_wdata      = mem_rdata;
                res_dval_next = mem_rdata;
                state_next    = S_FINISH;
            end
            S_ALU:
            begin
                if (alu_rsp.done)
                begin
                    rf_we         = 1'b1;
                    rf_waddr      = ir_rd;
                    rf_wdata      = alu_result;
                    res_wreg_next = 1'b1;
                    res_dreg_next = ir_rd;
                    res_dval_next = alu_result;
                    res_dz_next   = alu_rsp.div_zero;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Move the result into the output register once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    halted_next    = halt_reg;
                    opcode_next    = res_opcode_reg;
                    wreg_next      = res_wreg_reg;
                    dreg_next      = res_dreg_reg;
                    dval_next      = res_dval_reg;
                    wmem_next      = res_wmem_reg;
                    maddr_next     = res_maddr_reg;
                    dz_next        = res_dz_reg;
                    npc_next       = pc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, architectural registers and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pc_reg         <= '0;
            halt_reg       <= 1'b0;
            ir_reg         <= '0;
            a_reg          <= '0;
            res_opcode_reg <= '0;
            res_wreg_reg   <= 1'b0;
            res_dreg_reg   <= '0;
            res_dval_reg   <= '0;
            res_wmem_reg   <= 1'b0;
            res_maddr_reg  <= '0;
            res_dz_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            halted_reg     <= 1'b0;
            opcode_reg     <= '0;
            wreg_reg       <= 1'b0;
            dreg_reg       <= '0;
            dval_reg       <= '0;
            wmem_reg       <= 1'b0;
            maddr_reg      <= '0;
            dz_reg         <= 1'b0;
            npc_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            halt_reg       <= halt_next;
            ir_reg         <= ir_next;
            a_reg          <= a_next;
            res_opcode_reg <= res_opcode_next;
            res_wreg_reg   <= res_wreg_next;
            res_dreg_reg   <= res_dreg_next;
            res_dval_reg   <= res_dval_next;
            res_wmem_reg   <= res_wmem_next;
            res_maddr_reg  <= res_maddr_next;
            res_dz_reg     <= res_dz_next;
            out_valid_reg  <= out_valid_next;
            halted_reg     <= halted_next;
            opcode_reg     <= opcode_next;
            wreg_reg       <= wreg_next;
            dreg_reg       <= dreg_next;
            dval_reg       <= dval_next;
            wmem_reg       <= wmem_next;
            maddr_reg      <= maddr_next;
            dz_reg         <= dz_next;
            npc_reg        <= npc_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign halted          = halted_reg;
    assign executed_opcode = opcode_reg;
    assign reg_written     = wreg_reg;
    assign dest_reg        = dreg_reg;
    assign dest_value      = dval_reg;
    assign mem_written     = wmem_reg;
    assign mem_address     = maddr_reg;
    assign divide_by_zero  = dz_reg;
    assign next_pc         = npc_reg;

endmodule

// File: rtl/core/t16c_checker.sv
// Port-level assertions for the tiny 16-bit CPU step block and the bind that attaches them.
module t16c_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  executed_opcode,
    input  logic        reg_written,
    input  logic [15:0] dest_value,
    input  logic        mem_written,
    input  logic        divide_by_zero
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // One request at a time: the block is busy in the cycle after a transfer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transfer");

    // A step writes at most one of a register or memory, never both.
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(reg_written && mem_written))
        else $error("result reports both a register and a memory write");

    // A zero divisor only shows on a divide, which then writes all ones.
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |->
            reg_written && (executed_opcode == t16c_pkg::OP_DIV) && (dest_value == 16'hFFFF))
        else $error("divide by zero flag without an all-ones divide result");

    // Reported memory writes come from store instructions only; preloads do not report theirs.
    a_store_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mem_written |-> executed_opcode == t16c_pkg::OP_STORE)
        else $error("memory write reported for a non-store instruction");

endmodule

bind tiny_16bit_cpu_step t16c_checker u_t16c_checker (.*);
